// ===== design/hbme_pkg.sv =====
`timescale 1ns / 1ps

package hbme_pkg;

    localparam int unsigned LANES       = 4;
    localparam int unsigned SYM_W       = 8;
    localparam int unsigned DIM_W       = 3;
    localparam int unsigned KEY_ROW_W   = 32;
    localparam int unsigned VALUE_W     = 18;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned COL_W       = 2;

    // Register index map of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_DIM  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROW3 = 3'd4;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             message_end;
    } sym_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] cipher_value;
        logic               block_last;
        logic               message_last;
    } res_item_t;

    // One finished block, lanes past the block length already zeroed
    typedef struct packed {
        logic [LANES-1:0][SYM_W-1:0] sym;
        logic [DIM_W-1:0]            dim;
        logic                        msg_end;
    } blk_t;

    typedef logic [LANES-1:0][KEY_ROW_W-1:0] key_rows_t;

endpackage

// ===== design/hbme_front.sv =====
`timescale 1ns / 1ps

module hbme_front #(
    parameter int unsigned MAX_DIMENSION = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sym_valid,
    output logic                     sym_stall,
    input  hbme_pkg::sym_item_t      sym_data,
    input  logic [hbme_pkg::DIM_W-1:0] dim,
    input  logic                     q_full,
    output logic                     push,
    output hbme_pkg::blk_t           push_data
);
    import hbme_pkg::*;

    localparam int unsigned FILL_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;

    logic [SYM_W-1:0]  buf_reg [MAX_DIMENSION];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [DIM_W-1:0]  held;
    logic              accept;
    logic              complete;

    assign sym_stall = q_full;
    assign accept    = sym_valid && !q_full;
    assign held      = DIM_W'(fill_reg) + DIM_W'(1);
    assign complete  = (held >= dim) || sym_data.message_end;
    assign push      = accept && complete;

    // Assemble the block: incoming symbol at the fill slot, zero past held or dim
    always_comb
    begin
        push_data.dim     = dim;
        push_data.msg_end = sym_data.message_end;
        for (int w = 0; w < LANES; w++)
        begin
            push_data.sym[w] = '0;
            if (w < MAX_DIMENSION && DIM_W'(w) < held && DIM_W'(w) < dim)
            begin
                if (FILL_W'(w) == fill_reg)
                    push_data.sym[w] = sym_data.symbol;
                else
                    push_data.sym[w] = buf_reg[w];
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            if (complete)
                fill_next = '0;
            else
                fill_next = held[FILL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            buf_reg[fill_reg] <= sym_data.symbol;
    end

endmodule

// ===== design/hbme_queue.sv =====
`timescale 1ns / 1ps

module hbme_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hbme_pkg::blk_t push_data,
    output logic           full,
    input  logic           pop,
    output hbme_pkg::blk_t pop_data,
    output logic           empty
);
    import hbme_pkg::*;

    blk_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ===== design/hbme_back.sv =====
`timescale 1ns / 1ps

module hbme_back (
    input  logic                clk,
    input  logic                rst_n,
    input  hbme_pkg::key_rows_t key_rows,
    input  logic                q_empty,
    input  hbme_pkg::blk_t      q_data,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_stall,
    output hbme_pkg::res_item_t res_data
);
    import hbme_pkg::*;

    blk_t             cur_reg;
    logic             cur_valid_reg;
    logic             cur_valid_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    res_item_t        res_data_reg;
    res_item_t        res_data_next;
    logic             out_open;
    logic             fire;
    logic             last_col;
    logic [VALUE_W-1:0] dot;

    assign out_open = !res_valid_reg || !res_stall;
    assign fire     = cur_valid_reg && out_open;
    assign last_col = (DIM_W'(col_reg) + DIM_W'(1)) == cur_reg.dim;
    assign pop      = !q_empty && (!cur_valid_reg || (fire && last_col));

    // Dot product of the block with key column col_reg
    always_comb
    begin
        dot = '0;
        for (int w = 0; w < LANES; w++)
            dot = dot + VALUE_W'((2*SYM_W)'(cur_reg.sym[w])
                                 * (2*SYM_W)'(key_rows[w][col_reg*SYM_W +: SYM_W]));
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        col_next       = col_reg;
        if (fire)
        begin
            col_next = col_reg + COL_W'(1);
            if (last_col)
            begin
                cur_valid_next = 1'b0;
                col_next       = '0;
            end
        end
        if (pop)
            cur_valid_next = 1'b1;

        res_valid_next = res_valid_reg && res_stall;
        res_data_next  = res_data_reg;
        if (fire)
        begin
            res_valid_next             = 1'b1;
            res_data_next.cipher_value = dot;
            res_data_next.block_last   = last_col;
            res_data_next.message_last = last_col && cur_reg.msg_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            col_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            col_reg       <= col_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_data;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_col_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (DIM_W'(col_reg) < cur_reg.dim))
        else $error("column index past block dimension");

endmodule

// ===== design/hill_block_matrix_encrypt_core.sv =====
`timescale 1ns / 1ps
// A block closed by a symbol goes through the block queue and the back-end block register to the output.
// Throughput: one symbol per cycle while the queue is not full; each block yields one result per
//   key column of the key dimension, one per cycle from the back-end column datapath unless stalled.
// A 2-entry block queue between front and back absorbs output stalls.
// Reset (rst_n, async low): empties the queue and block fill, key dimension = 1, key rows = 0.
module hill_block_matrix_encrypt_core #(
    parameter int unsigned MAX_DIMENSION = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sym_valid,
    output logic                                 sym_stall,
    input  hbme_pkg::sym_item_t                  sym_data,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output hbme_pkg::res_item_t                  res_data,
    input  logic                                 cfg_we,
    input  logic [hbme_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hbme_pkg::KEY_ROW_W-1:0]       cfg_data
);
    import hbme_pkg::*;

    // Block length limit: never above the lane count, never below one
    localparam int unsigned DIM_LIM_I = (MAX_DIMENSION > LANES) ? LANES :
                                        (MAX_DIMENSION < 1) ? 1 : MAX_DIMENSION;
    localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(DIM_LIM_I);

    logic [DIM_W-1:0] key_dim_reg;
    logic [DIM_W-1:0] key_dim_next;
    key_rows_t        key_rows_reg;
    key_rows_t        key_rows_next;
    logic [DIM_W-1:0] dim_eff;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    blk_t push_data;
    blk_t pop_data;

    // Configuration writes: unknown indexes drop silently
    always_comb
    begin
        key_dim_next  = key_dim_reg;
        key_rows_next = key_rows_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_DIM:  key_dim_next     = cfg_data[DIM_W-1:0];
                REG_KEY_ROW0: key_rows_next[0] = cfg_data;
                REG_KEY_ROW1: key_rows_next[1] = cfg_data;
                REG_KEY_ROW2: key_rows_next[2] = cfg_data;
                REG_KEY_ROW3: key_rows_next[3] = cfg_data;
                default:      key_dim_next     = key_dim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_dim_reg  <= DIM_W'(1);
            key_rows_reg <= '0;
        end
        else
        begin
            key_dim_reg  <= key_dim_next;
            key_rows_reg <= key_rows_next;
        end
    end

    // Dimension zero acts as one; large values saturate at the limit
    always_comb
    begin
        if (key_dim_reg == '0)
            dim_eff = DIM_W'(1);
        else if (key_dim_reg > DIM_LIM)
            dim_eff = DIM_LIM;
        else
            dim_eff = key_dim_reg;
    end

    // Front: collect symbols, hand each closed block to the queue
    hbme_front #(
        .MAX_DIMENSION (DIM_LIM_I)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym_data  (sym_data),
        .dim       (dim_eff),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    hbme_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // Back: one key column per cycle into the output register, unless the output stalls
    hbme_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_rows  (key_rows_reg),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

// ===== tb/hill_product_checker.sv =====
`timescale 1ns / 1ps

module hill_product_checker #(
    parameter int unsigned MAX_DIMENSION = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sym_valid,
    input  logic                             sym_stall,
    input  hbme_pkg::sym_item_t              sym_data,
    input  logic                             res_valid,
    input  logic                             res_stall,
    input  hbme_pkg::res_item_t              res_data,
    input  logic                             cfg_we,
    input  logic [hbme_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hbme_pkg::KEY_ROW_W-1:0]   cfg_data,
    output int                               mismatch_count,
    output int                               columns_pending
);
    import hbme_pkg::*;

    logic [DIM_W-1:0]            key_dim;
    key_rows_t                   key_matrix;
    logic [LANES-1:0][SYM_W-1:0] block_syms;
    logic [COL_W-1:0]            fill;
    res_item_t                   column_queue[$];

    // Zero acts as one, anything past the lower of the lane count and MAX_DIMENSION saturates
    function automatic int unsigned active_dim(input logic [DIM_W-1:0] d);
        int unsigned lim;
        lim = (MAX_DIMENSION > LANES) ? LANES : MAX_DIMENSION;
        if (lim < 1)
            lim = 1;
        if (d == 0)
            return 1;
        if (d > lim)
            return lim;
        return d;
    endfunction

    // Store the symbol; on a full block or message end, queue one product per key column
    task automatic encrypt_symbol(input sym_item_t it);
        int unsigned n;
        int unsigned held;
        logic [31:0] sum;
        res_item_t   col;
        n = active_dim(key_dim);
        block_syms[fill] = it.symbol;
        held = fill + 1;
        if (held < n && !it.message_end)
        begin
            fill = COL_W'(held);
        end
        else
        begin
            for (int unsigned c = 0; c < n; c++)
            begin
                sum = '0;
                for (int unsigned w = 0; w < n; w++)
                begin
                    if (w < held)
                        sum += 32'(block_syms[w]) * 32'(key_matrix[w][c*SYM_W +: SYM_W]);
                end
                col.cipher_value = sum[VALUE_W-1:0];
                col.block_last   = (c + 1 == n);
                col.message_last = (c + 1 == n) && it.message_end;
                column_queue.push_back(col);
            end
            fill = '0;
        end
    endtask

    task automatic compare_column(input res_item_t got);
        res_item_t want;
        if (column_queue.size() == 0)
        begin
            $error("unexpected result: cipher_value %0d block_last %0b message_last %0b",
                   got.cipher_value, got.block_last, got.message_last);
            mismatch_count++;
        end
        else
        begin
            want = column_queue.pop_front();
            if (got.cipher_value !== want.cipher_value)
            begin
                $error("cipher_value: expected %0d, got %0d",
                       want.cipher_value, got.cipher_value);
                mismatch_count++;
            end
            if (got.block_last !== want.block_last)
            begin
                $error("block_last: expected %0b, got %0b", want.block_last, got.block_last);
                mismatch_count++;
            end
            if (got.message_last !== want.message_last)
            begin
                $error("message_last: expected %0b, got %0b",
                       want.message_last, got.message_last);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_dim         = DIM_W'(1);
            key_matrix      = '0;
            block_syms      = '0;
            fill            = '0;
            mismatch_count  = 0;
            columns_pending = 0;
            column_queue.delete();
        end
        else
        begin
            // A result never leaves on the edge its closing symbol enters
            if (res_valid && !res_stall)
                compare_column(res_data);
            if (sym_valid && !sym_stall)
                encrypt_symbol(sym_data);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_DIM:  key_dim       = cfg_data[DIM_W-1:0];
                    REG_KEY_ROW0: key_matrix[0] = cfg_data;
                    REG_KEY_ROW1: key_matrix[1] = cfg_data;
                    REG_KEY_ROW2: key_matrix[2] = cfg_data;
                    REG_KEY_ROW3: key_matrix[3] = cfg_data;
                    default:      ;
                endcase
            end
            columns_pending = column_queue.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import hbme_pkg::*;

    localparam int unsigned MAX_DIMENSION  = 4;
    localparam int unsigned RANDOM_SYMBOLS = 340;
    // Take the limit well above the worst-case run time
    localparam int unsigned CYCLE_LIMIT    = 400000;
    // Covers the path to the first result plus the block queue, with margin
    localparam int unsigned SETTLE_CYCLES  = 8;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   sym_valid = 1'b0;
    logic                   sym_stall;
    sym_item_t              sym_data  = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    res_item_t              res_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [KEY_ROW_W-1:0]   cfg_data  = '0;

    int          mismatch_count;
    int          columns_pending;
    // While set, neither side idles: back-to-back transactions
    bit          calm        = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned stall_left  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    hill_block_matrix_encrypt_core #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym_data  (sym_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hill_product_checker #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .sym_valid       (sym_valid),
        .sym_stall       (sym_stall),
        .sym_data        (sym_data),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res_data        (res_data),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .columns_pending (columns_pending)
    );

    // Mostly short gaps, now and then a long one
    function automatic int unsigned gap_length();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic int unsigned stall_length();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // Favor the byte extremes so full-scale products show up often
    function automatic logic [SYM_W-1:0] rand_symbol();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return SYM_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [KEY_ROW_W-1:0] rand_key_row();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return $urandom;
    endfunction

    // Drive one register write for a single cycle, then drop the enable
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [KEY_ROW_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Offer one symbol after a random gap and hold it until the core takes it
    task automatic send_symbol(input logic [SYM_W-1:0] value, input logic last);
        int unsigned gap;
        gap = gap_length();
        @(negedge clk);
        if (gap != 0)
        begin
            // Scramble the idle payload: the core must ignore it
            sym_valid            = 1'b0;
            sym_data.symbol      = SYM_W'($urandom);
            sym_data.message_end = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        sym_valid            = 1'b1;
        sym_data.symbol      = value;
        sym_data.message_end = last;
        @(posedge clk);
        while (sym_stall)
            @(posedge clk);
    endtask

    task automatic send_message(input int unsigned len, input bit mark_end);
        for (int unsigned i = 0; i < len; i++)
            send_symbol(rand_symbol(), mark_end && (i + 1 == len));
    endtask

    // Drop valid, wait for every expected column, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        sym_valid = 1'b0;
        while (columns_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Result-side back-pressure, changed only at falling edges
    always
    begin
        @(negedge clk);
        if (stall_left != 0)
        begin
            res_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            res_stall  = 1'b0;
            stall_left = stall_length();
        end
    end

    // Watchdog: a hung handshake or a missing result ends here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned random_sent;
        int unsigned phase;
        int unsigned dim_val;
        int unsigned len;
        bit          mark_end;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: dimension one, all-zero key, so every product is zero
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h5A, 1'b1);
        wait_idle();

        // Full-scale block: every column hits the largest product
        write_reg(REG_KEY_DIM, 32'd4);
        write_reg(REG_KEY_ROW0, 32'hFFFF_FFFF);
        write_reg(REG_KEY_ROW1, 32'hFFFF_FFFF);
        write_reg(REG_KEY_ROW2, 32'hFFFF_FFFF);
        write_reg(REG_KEY_ROW3, 32'hFFFF_FFFF);
        // Message end on the fourth symbol: no extra padded block may follow
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'hFF, 1'b1);
        wait_idle();

        // Distinct key bytes; short final blocks get zero padding
        write_reg(REG_KEY_ROW0, 32'h0403_0201);
        write_reg(REG_KEY_ROW1, 32'h0807_0605);
        write_reg(REG_KEY_ROW2, 32'h0C0B_0A09);
        write_reg(REG_KEY_ROW3, 32'h100F_0E0D);
        send_symbol(8'd1, 1'b0);
        send_symbol(8'd2, 1'b0);
        send_symbol(8'd3, 1'b1);
        send_symbol(8'd7, 1'b1);
        wait_idle();

        // Dimension zero acts as one; upper data bits must be dropped
        write_reg(REG_KEY_DIM, 32'hFFFF_FFF8);
        send_symbol(8'd200, 1'b0);
        send_symbol(8'd1, 1'b1);
        wait_idle();

        // Oversized dimension saturates to four
        write_reg(REG_KEY_DIM, 32'd7);
        send_symbol(8'd10, 1'b0);
        send_symbol(8'd20, 1'b0);
        send_symbol(8'd30, 1'b0);
        send_symbol(8'd40, 1'b0);
        wait_idle();

        // Writes to unmapped indexes must leave the key alone
        for (int unsigned i = REG_KEY_ROW3 + 1; i < 2 ** CFG_INDEX_W; i++)
            write_reg(CFG_INDEX_W'(i), 32'hFFFF_FFFF);

        // Lower the dimension mid-block: the next symbol closes it at once
        send_symbol(8'd11, 1'b0);
        send_symbol(8'd12, 1'b0);
        send_symbol(8'd13, 1'b0);
        wait_idle();
        write_reg(REG_KEY_DIM, 32'd2);
        send_symbol(8'd14, 1'b0);

        // Raise it mid-block: the held symbol stays part of a longer block
        send_symbol(8'd21, 1'b0);
        wait_idle();
        write_reg(REG_KEY_DIM, 32'd4);
        send_symbol(8'd22, 1'b0);
        send_symbol(8'd23, 1'b0);
        send_symbol(8'd24, 1'b1);
        wait_idle();

        // Random phases: reprogram while idle, then stream messages
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_SYMBOLS)
        begin
            wait_idle();
            calm = (phase % 4 == 3);
            if (phase == 0 || $urandom_range(0, 3) != 0)
            begin
                dim_val = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                      : $urandom_range(1, 4);
                write_reg(REG_KEY_DIM, ($urandom & ~32'h7) | dim_val);
            end
            for (int unsigned r = 0; r < LANES; r++)
            begin
                if ($urandom_range(0, 1) != 0)
                    write_reg(REG_KEY_ROW0 + CFG_INDEX_W'(r), rand_key_row());
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(REG_KEY_ROW3 + 1, 2 ** CFG_INDEX_W - 1)),
                          $urandom);

            // Unterminated messages leave a partial block across the next reprogram
            repeat ($urandom_range(1, 4))
            begin
                len      = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16)
                                                       : $urandom_range(1, 8);
                mark_end = ($urandom_range(0, 9) != 0);
                send_message(len, mark_end);
                random_sent += len;
            end
            phase++;
        end

        // Drain everything, then give the verdict
        calm = 1'b0;
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/hbme_pkg.sv
design/hbme_front.sv
design/hbme_queue.sv
design/hbme_back.sv
design/hill_block_matrix_encrypt_core.sv
tb/hill_product_checker.sv
tb/testbench.sv
